// ----- design/fsct_pkg.sv -----
`timescale 1ns / 1ps
package fsct_pkg;

  localparam int PIXEL_BITS  = 8;
  localparam int RING_SLOTS  = 16;
  localparam int WORD_SLOTS  = 8;
  localparam int WORD_BITS   = 64;
  localparam int ARC_FAST9   = 9;
  localparam int ARC_FAST12  = 12;
  localparam int GROUPS      = 4;
  localparam int GROUP_SLOTS = RING_SLOTS / GROUPS;

  localparam int CENTER_BITS = 8;
  localparam int THR_BITS    = 8;
  localparam int MODE_BITS   = 2;
  localparam int SCORE_BITS  = 12;
  localparam int SCORE_MAX   = 4095;
  localparam int CFG_IDX_BITS  = 4;
  localparam int CFG_DATA_BITS = 8;

  localparam int CMP_W   = ((PIXEL_BITS > THR_BITS) ? PIXEL_BITS : THR_BITS) + 2;
  localparam int GRP_W   = PIXEL_BITS + $clog2(GROUP_SLOTS);
  localparam int SUM_W   = PIXEL_BITS + $clog2(RING_SLOTS);
  localparam int SAT_W   = (SUM_W > SCORE_BITS) ? SUM_W : SCORE_BITS;

  localparam logic [MODE_BITS-1:0] MODE_FAST4  = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_FAST9  = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_FAST12 = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_RSVD   = 2'd3;

  localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MODE      = 4'd1;

  localparam logic [THR_BITS-1:0]  THR_RESET  = 8'd20;
  localparam logic [MODE_BITS-1:0] MODE_RESET = MODE_FAST9;

  typedef logic [PIXEL_BITS-1:0] pix_t;
  typedef logic [RING_SLOTS-1:0] ring_mask_t;
  typedef logic [GRP_W-1:0]      grp_sum_t;
  typedef logic [SUM_W-1:0]      sum_t;

endpackage

// ----- design/fsct_if.sv -----
`timescale 1ns / 1ps
interface fsct_in_if import fsct_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CENTER_BITS-1:0] center_pixel;
  logic [WORD_BITS-1:0]   ring_pixels_low;
  logic [WORD_BITS-1:0]   ring_pixels_high;

  modport source (output valid, center_pixel, ring_pixels_low, ring_pixels_high,
                  input ready);
  modport sink (input valid, center_pixel, ring_pixels_low, ring_pixels_high,
                output ready);
endinterface

interface fsct_out_if import fsct_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  is_corner;
  logic                  corner_polarity;
  logic [SCORE_BITS-1:0] corner_score;

  modport source (output valid, is_corner, corner_polarity, corner_score,
                  input ready);
  modport sink (input valid, is_corner, corner_polarity, corner_score,
                output ready);
endinterface

interface fsct_cfg_if import fsct_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  reg_index;
  logic [CFG_DATA_BITS-1:0] wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink (input valid, reg_index, wr_data, output ready);
endinterface

// ----- design/fast_segment_corner_test.sv -----
`timescale 1ns / 1ps
// channel   dir  contents
// in_ch     in   center_pixel, ring_pixels_low, ring_pixels_high
// out_ch    out  is_corner, corner_polarity, corner_score
// cfg_ch    in   reg_index, wr_data (0 = pixel_threshold, 1 = corner_mode)
//
// three register stages: classify, partial sums and arc search, final sum and select
// one transaction per cycle in and out while out_ch.ready is high; an accepted one passes stage 1, 2, 3 to out valid
// each stage moves on when it is empty or the next one moves, so bubbles close up
// rst_n (synchronous, active low) clears the stage valid bits and loads the config
// reset values; cfg_ready is always high

module fast_segment_corner_test import fsct_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  fsct_in_if.sink    in_ch,
  fsct_out_if.source out_ch,
  fsct_cfg_if.sink   cfg_ch
);

  logic [THR_BITS-1:0]  thr_r;
  logic [MODE_BITS-1:0] mode_r;

  logic adv1, adv2, adv3;

  // stage 1
  logic                 s1_v_r;
  ring_mask_t           s1_dark_r, s1_bright_r;
  pix_t                 s1_ex_r [RING_SLOTS];
  logic [MODE_BITS-1:0] s1_mode_r;
  ring_mask_t           s1_dark_nxt, s1_bright_nxt;
  pix_t                 s1_ex_nxt [RING_SLOTS];

  // stage 2
  logic                 s2_v_r;
  grp_sum_t             s2_dgrp_r [GROUPS];
  grp_sum_t             s2_bgrp_r [GROUPS];
  grp_sum_t             s2_d4_r, s2_b4_r;
  logic                 s2_drun_r, s2_brun_r, s2_d4ok_r, s2_b4ok_r;
  logic [MODE_BITS-1:0] s2_mode_r;
  grp_sum_t             s2_dgrp_nxt [GROUPS];
  grp_sum_t             s2_bgrp_nxt [GROUPS];
  grp_sum_t             s2_d4_nxt, s2_b4_nxt;
  logic                 s2_drun_nxt, s2_brun_nxt;

  // stage 3 / output
  logic                  s3_v_r;
  logic                  s3_corner_r, s3_pol_r;
  logic [SCORE_BITS-1:0] s3_score_r;
  logic                  s3_corner_nxt, s3_pol_nxt;
  logic [SCORE_BITS-1:0] s3_score_nxt;
  sum_t                  dsum, bsum, sel_sum;

  assign adv3 = !s3_v_r || out_ch.ready;
  assign adv2 = !s2_v_r || adv3;
  assign adv1 = !s1_v_r || adv2;

  assign in_ch.ready  = adv1;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid           = s3_v_r;
  assign out_ch.is_corner       = s3_corner_r;
  assign out_ch.corner_polarity = s3_pol_r;
  assign out_ch.corner_score    = s3_score_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THR_RESET;
      mode_r <= MODE_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        CFG_THRESHOLD: thr_r  <= THR_BITS'(cfg_ch.wr_data);
        CFG_MODE:      mode_r <= MODE_BITS'(cfg_ch.wr_data);
        default: ;
      endcase
    end
  end

  // classify
  always_comb begin
    logic signed [CMP_W-1:0] c, t, lo, hi, p;
    logic [WORD_BITS-1:0] word;
    c = $signed(CMP_W'(pix_t'(in_ch.center_pixel)));
    t = $signed(CMP_W'(thr_r));
    lo = c - t;
    hi = c + t;
    for (int k = 0; k < RING_SLOTS; k++) begin
      word = (k < WORD_SLOTS) ? in_ch.ring_pixels_low : in_ch.ring_pixels_high;
      p = $signed(CMP_W'(pix_t'(word >> ((k % WORD_SLOTS) * PIXEL_BITS))));
      s1_dark_nxt[k]   = 1'b0;
      s1_bright_nxt[k] = 1'b0;
      s1_ex_nxt[k]     = '0;
      if (p < lo) begin
        s1_dark_nxt[k] = 1'b1;
        s1_ex_nxt[k]   = pix_t'(lo - p);
      end else if (p >= hi) begin
        s1_bright_nxt[k] = 1'b1;
        s1_ex_nxt[k]     = pix_t'(p - hi);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv1) begin
      s1_v_r <= in_ch.valid;
    end
    if (adv1) begin
      s1_dark_r   <= s1_dark_nxt;
      s1_bright_r <= s1_bright_nxt;
      s1_ex_r     <= s1_ex_nxt;
      s1_mode_r   <= mode_r;
    end
  end

  // partial sums and arc search
  always_comb begin
    logic r9d, r12d, r9b, r12b, okd, okb;
    r9d = 1'b0; r12d = 1'b0; r9b = 1'b0; r12b = 1'b0;
    for (int g = 0; g < GROUPS; g++) begin
      s2_dgrp_nxt[g] = '0;
      s2_bgrp_nxt[g] = '0;
      for (int j = 0; j < GROUP_SLOTS; j++) begin
        s2_dgrp_nxt[g] += s1_dark_r[g*GROUP_SLOTS+j]
                          ? GRP_W'(s1_ex_r[g*GROUP_SLOTS+j]) : '0;
        s2_bgrp_nxt[g] += s1_bright_r[g*GROUP_SLOTS+j]
                          ? GRP_W'(s1_ex_r[g*GROUP_SLOTS+j]) : '0;
      end
    end
    s2_d4_nxt = '0;
    s2_b4_nxt = '0;
    for (int g = 0; g < GROUPS; g++) begin
      s2_d4_nxt += s1_dark_r[g*GROUP_SLOTS]   ? GRP_W'(s1_ex_r[g*GROUP_SLOTS]) : '0;
      s2_b4_nxt += s1_bright_r[g*GROUP_SLOTS] ? GRP_W'(s1_ex_r[g*GROUP_SLOTS]) : '0;
    end
    for (int s = 0; s < RING_SLOTS; s++) begin
      okd = 1'b1;
      okb = 1'b1;
      for (int j = 0; j < ARC_FAST9; j++) begin
        okd &= s1_dark_r[(s + j) % RING_SLOTS];
        okb &= s1_bright_r[(s + j) % RING_SLOTS];
      end
      r9d |= okd;
      r9b |= okb;
      okd = 1'b1;
      okb = 1'b1;
      for (int j = 0; j < ARC_FAST12; j++) begin
        okd &= s1_dark_r[(s + j) % RING_SLOTS];
        okb &= s1_bright_r[(s + j) % RING_SLOTS];
      end
      r12d |= okd;
      r12b |= okb;
    end
    s2_drun_nxt = (s1_mode_r == MODE_FAST12) ? r12d : r9d;
    s2_brun_nxt = (s1_mode_r == MODE_FAST12) ? r12b : r9b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv2) begin
      s2_v_r <= s1_v_r;
    end
    if (adv2) begin
      s2_dgrp_r <= s2_dgrp_nxt;
      s2_bgrp_r <= s2_bgrp_nxt;
      s2_d4_r   <= s2_d4_nxt;
      s2_b4_r   <= s2_b4_nxt;
      s2_drun_r <= s2_drun_nxt;
      s2_brun_r <= s2_brun_nxt;
      s2_d4ok_r <= (s1_dark_r[0] || s1_dark_r[8]) && (s1_dark_r[4] || s1_dark_r[12]);
      s2_b4ok_r <= (s1_bright_r[0] || s1_bright_r[8])
                   && (s1_bright_r[4] || s1_bright_r[12]);
      s2_mode_r <= s1_mode_r;
    end
  end

  // final sum, select and clamp
  always_comb begin
    dsum = '0;
    bsum = '0;
    for (int g = 0; g < GROUPS; g++) begin
      dsum += SUM_W'(s2_dgrp_r[g]);
      bsum += SUM_W'(s2_bgrp_r[g]);
    end
    s3_corner_nxt = 1'b0;
    s3_pol_nxt    = 1'b0;
    sel_sum       = '0;
    case (s2_mode_r)
      MODE_FAST4: begin
        if (s2_d4ok_r) begin
          s3_corner_nxt = 1'b1;
          sel_sum       = SUM_W'(s2_d4_r);
        end else if (s2_b4ok_r) begin
          s3_corner_nxt = 1'b1;
          s3_pol_nxt    = 1'b1;
          sel_sum       = SUM_W'(s2_b4_r);
        end
      end
      MODE_FAST9, MODE_FAST12: begin
        if (s2_drun_r) begin
          s3_corner_nxt = 1'b1;
          sel_sum       = dsum;
        end else if (s2_brun_r) begin
          s3_corner_nxt = 1'b1;
          s3_pol_nxt    = 1'b1;
          sel_sum       = bsum;
        end
      end
      default: ;
    endcase
    if (SAT_W'(sel_sum) > SAT_W'(SCORE_MAX)) begin
      s3_score_nxt = SCORE_BITS'(SCORE_MAX);
    end else begin
      s3_score_nxt = SCORE_BITS'(sel_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv3) begin
      s3_v_r <= s2_v_r;
    end
    if (adv3) begin
      s3_corner_r <= s3_corner_nxt;
      s3_pol_r    <= s3_pol_nxt;
      s3_score_r  <= s3_score_nxt;
    end
  end

  a_no_corner_zero: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r && !s3_corner_r |-> !s3_pol_r && s3_score_r == '0)
    else $error("non-corner result carries polarity or score");

  a_classes_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> (s1_dark_r & s1_bright_r) == '0)
    else $error("ring slot both dark and bright");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> s1_v_r)
    else $error("accepted transaction lost at stage one");

  a_reserved_mode: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && adv3 && s2_mode_r == MODE_RSVD |=> !s3_corner_r)
    else $error("reserved mode reported a corner");

endmodule
